// File: sv/ktd_pkg.sv
package ktd_pkg;

  // Input event codes
  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_TIMEOUT = 2'd1,
    ACT_RESIZE  = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  // Result kinds
  typedef enum logic [3:0] {
    K_PLAIN  = 4'd0,
    K_ESC    = 4'd1,
    K_UP     = 4'd2,
    K_DOWN   = 4'd3,
    K_RIGHT  = 4'd4,
    K_LEFT   = 4'd5,
    K_HOME   = 4'd6,
    K_END    = 4'd7,
    K_DEL    = 4'd8,
    K_PGUP   = 4'd9,
    K_PGDN   = 4'd10,
    K_RESIZE = 4'd11
  } kind_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC   = 3'd1,
    PH_CSI   = 3'd2,
    PH_SS3   = 3'd3,
    PH_DIGIT = 3'd4
  } phase_t;

  // Character constants
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_5      = 8'h35;
  localparam logic [7:0] CH_6      = 8'h36;
  localparam logic [7:0] CH_9      = 8'h39;

  localparam int MAX_RES = 4;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } result_t;

  // All results caused by one input item; cnt is 1..4 when loaded
  typedef struct packed {
    logic [2:0]                 cnt;
    result_t [MAX_RES-1:0]      res;
  } bundle_t;

endpackage

// File: sv/ktd_core.sv
module ktd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // [1:0] action, [9:2] in_byte, [15:10] zero
  input  logic             free,      // result register can take a bundle this cycle
  output logic             load,
  output ktd_pkg::bundle_t bundle
);
  import ktd_pkg::*;

  logic       in_valid;
  action_t    in_action;
  logic [7:0] in_byte;
  phase_t     phase, phase_next;
  logic [7:0] digit, digit_next;
  logic [2:0] nres;
  logic       take;

  // Decode one event against the current phase
  always_comb begin
    nres       = 3'd0;
    phase_next = phase;
    digit_next = digit;
    for (int i = 0; i < MAX_RES; i++) begin
      bundle.res[i] = '{kind: K_PLAIN, data: 8'h00};
    end
    case (in_action)
      ACT_BYTE: begin
        case (phase)
          PH_ESC: begin
            if (in_byte == CH_LBRACK) begin
              phase_next = PH_CSI;
            end else if (in_byte == CH_O) begin
              phase_next = PH_SS3;
            end else begin
              bundle.res[0] = '{kind: K_ESC, data: 8'h00};
              bundle.res[1] = '{kind: K_PLAIN, data: in_byte};
              nres          = 3'd2;
              phase_next    = PH_IDLE;
            end
          end
          PH_CSI: begin
            if (in_byte >= CH_0 && in_byte <= CH_9) begin
              digit_next = in_byte;
              phase_next = PH_DIGIT;
            end else begin
              case (in_byte)
                CH_A:    bundle.res[0].kind = K_UP;
                CH_B:    bundle.res[0].kind = K_DOWN;
                CH_C:    bundle.res[0].kind = K_RIGHT;
                CH_D:    bundle.res[0].kind = K_LEFT;
                CH_H:    bundle.res[0].kind = K_HOME;
                CH_F:    bundle.res[0].kind = K_END;
                default: bundle.res[0].kind = K_ESC;
              endcase
              nres       = 3'd1;
              phase_next = PH_IDLE;
            end
          end
          PH_SS3: begin
            if (in_byte == CH_H) begin
              bundle.res[0].kind = K_HOME;
            end else if (in_byte == CH_F) begin
              bundle.res[0].kind = K_END;
            end else begin
              bundle.res[0].kind = K_ESC;
            end
            nres       = 3'd1;
            phase_next = PH_IDLE;
          end
          PH_DIGIT: begin
            bundle.res[0].kind = K_ESC;
            if (in_byte == CH_TILDE) begin
              if (digit == CH_3) begin
                bundle.res[0].kind = K_DEL;
              end else if (digit == CH_5) begin
                bundle.res[0].kind = K_PGUP;
              end else if (digit == CH_6) begin
                bundle.res[0].kind = K_PGDN;
              end
            end
            nres       = 3'd1;
            phase_next = PH_IDLE;
          end
          default: begin
            if (in_byte == CH_ESC) begin
              phase_next = PH_ESC;
            end else begin
              bundle.res[0] = '{kind: K_PLAIN, data: in_byte};
              nres          = 3'd1;
              phase_next    = PH_IDLE;
            end
          end
        endcase
      end
      ACT_TIMEOUT, ACT_RESIZE: begin
        // flush ESC and the bytes taken after it
        case (phase)
          PH_ESC: begin
            bundle.res[0].kind = K_ESC;
            nres               = 3'd1;
          end
          PH_CSI: begin
            bundle.res[0].kind = K_ESC;
            bundle.res[1]      = '{kind: K_PLAIN, data: CH_LBRACK};
            nres               = 3'd2;
          end
          PH_SS3: begin
            bundle.res[0].kind = K_ESC;
            bundle.res[1]      = '{kind: K_PLAIN, data: CH_O};
            nres               = 3'd2;
          end
          PH_DIGIT: begin
            bundle.res[0].kind = K_ESC;
            bundle.res[1]      = '{kind: K_PLAIN, data: CH_LBRACK};
            bundle.res[2]      = '{kind: K_PLAIN, data: digit};
            nres               = 3'd3;
          end
          default: nres = 3'd0;
        endcase
        phase_next = PH_IDLE;
        if (in_action == ACT_RESIZE) begin
          bundle.res[nres[1:0]] = '{kind: K_RESIZE, data: 8'h00};
          nres                  = nres + 3'd1;
        end
      end
      default: nres = 3'd0;
    endcase
    bundle.cnt = nres;
  end

  // Items without results never wait for the result register
  assign take     = in_valid && (free || nres == 3'd0);
  assign load     = take && nres != 3'd0;
  assign s_tready = !in_valid || take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_action <= action_t'(s_tdata[1:0]);
      in_byte   <= s_tdata[9:2];
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      digit <= 8'h00;
    end else if (take) begin
      phase <= phase_next;
      digit <= digit_next;
    end
  end

endmodule

// File: sv/ktd_emit.sv
module ktd_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ktd_pkg::bundle_t bundle,
  output logic             free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,   // [3:0] kind, [11:4] out_byte, [15:12] zero
  output logic             m_tlast
);
  import ktd_pkg::*;

  logic       b_valid;
  bundle_t    held;
  logic [1:0] idx;
  result_t    cur;
  logic       fire;

  assign cur      = held.res[idx];
  assign m_tvalid = b_valid;
  assign m_tdata  = {4'h0, cur.data, cur.kind};
  assign m_tlast  = ({1'b0, idx} + 3'd1) == held.cnt;
  assign fire     = b_valid && m_tready;
  assign free     = !b_valid || (fire && m_tlast);

  // Result register, one result handed out per cycle while m_tready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      idx     <= 2'd0;
    end else if (load) begin
      b_valid <= 1'b1;
      idx     <= 2'd0;
    end else if (fire) begin
      if (m_tlast) begin
        b_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
    if (load) begin
      held <= bundle;
    end
  end

endmodule

// File: sv/terminal_key_escape_decoder_unit.sv
// An accepted item passes the input register, then the result register, before
// its first result reaches the output. Throughput: one input item per cycle
// while each item gives at most one result and m_tready is high; an item with
// up to 4 results holds the result register, sending one per m_tready cycle.
// Reset (rst, synchronous, active high) returns the parser to idle, clears the
// held digit and drops any item or results in flight.
module terminal_key_escape_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] action, [9:2] in_byte, [15:10] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] kind, [11:4] out_byte, [15:12] zero
  output logic        m_tlast
);
  import ktd_pkg::*;

  logic    free;
  logic    load;
  bundle_t bundle;

  ktd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .free     (free),
    .load     (load),
    .bundle   (bundle)
  );

  ktd_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .bundle   (bundle),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // a bundle is only written when the result register is free
  a_load_free: assert property (@(posedge clk) disable iff (rst) load |-> free)
    else $error("bundle loaded while results pending");

  // every loaded bundle carries one to four results
  a_load_cnt: assert property (@(posedge clk) disable iff (rst)
    load |-> (bundle.cnt != 3'd0 && bundle.cnt <= 3'd4))
    else $error("bad result count");

  // final result taken with nothing new loaded leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast && !load) |=> !m_tvalid)
    else $error("output still valid after last result");

endmodule
